// ===== hw/rtl/dbcm_pkg.sv =====
// dbcm_pkg: shared types, constants and colour table for the dB level colour map.
// Used by every module under hw/rtl. No dependencies.
package dbcm_pkg;

  localparam int LevelW = 17;
  localparam int MagW   = 17;
  localparam int PosW   = 13;
  localparam int IdxW   = 5;
  localparam int FracW  = 8;
  localparam int ChanW  = 8;

  // floor(x / 10) == (x * 52429) >> 19 for every x up to 65536
  localparam int RecipW     = 16;
  localparam int ProdW      = MagW + RecipW;
  localparam logic [RecipW-1:0] Recip = 16'd52429;
  localparam int RecipShift = 19;

  localparam logic [IdxW-1:0] BlackIdx = 5'd18;

  typedef struct packed {
    logic [ChanW-1:0] r;
    logic [ChanW-1:0] g;
    logic [ChanW-1:0] b;
  } rgb_t;

  localparam rgb_t White = '{r: 8'd255, g: 8'd255, b: 8'd255};
  localparam rgb_t Black = '{r: 8'd0,   g: 8'd0,   b: 8'd0};

  function automatic rgb_t colour_row(input logic [IdxW-1:0] idx);
    rgb_t c;
    case (idx)
      5'd0:    c = '{8'd255, 8'd255, 8'd255};
      5'd1:    c = '{8'd240, 8'd254, 8'd216};
      5'd2:    c = '{8'd242, 8'd251, 8'd185};
      5'd3:    c = '{8'd253, 8'd245, 8'd143};
      5'd4:    c = '{8'd253, 8'd200, 8'd102};
      5'd5:    c = '{8'd252, 8'd144, 8'd66};
      5'd6:    c = '{8'd252, 8'd75,  8'd32};
      5'd7:    c = '{8'd237, 8'd28,  8'd41};
      5'd8:    c = '{8'd214, 8'd3,   8'd64};
      5'd9:    c = '{8'd183, 8'd3,   8'd101};
      5'd10:   c = '{8'd157, 8'd3,   8'd122};
      5'd11:   c = '{8'd122, 8'd3,   8'd126};
      5'd12:   c = '{8'd80,  8'd2,   8'd110};
      5'd13:   c = '{8'd45,  8'd2,   8'd89};
      5'd14:   c = '{8'd19,  8'd2,   8'd70};
      5'd15:   c = '{8'd1,   8'd3,   8'd53};
      5'd16:   c = '{8'd1,   8'd3,   8'd37};
      5'd17:   c = '{8'd1,   8'd2,   8'd19};
      default: c = Black;
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/dbcm_front.sv =====
// dbcm_front: two stages, magnitude of a negative level, then divide by 10.
// Depends on dbcm_pkg.
module dbcm_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [dbcm_pkg::LevelW-1:0]    level_db,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_neg,
  output logic [dbcm_pkg::PosW-1:0]      out_pos
);

  logic                         s1_valid;
  logic                         s1_neg;
  logic [dbcm_pkg::MagW-1:0]    s1_mag;
  logic                         s1_ready;
  logic                         s2_valid;
  logic                         s2_neg;
  logic [dbcm_pkg::PosW-1:0]    s2_pos;
  logic                         s2_ready;
  logic [dbcm_pkg::ProdW-1:0]   prod;

  assign s2_ready = !s2_valid || out_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  assign prod = dbcm_pkg::ProdW'(s1_mag) * dbcm_pkg::ProdW'(dbcm_pkg::Recip);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid <= in_valid;
      if (s2_ready) s2_valid <= s1_valid;
    end
    if (s1_ready && in_valid) begin
      s1_neg <= level_db[dbcm_pkg::LevelW-1];
      s1_mag <= dbcm_pkg::MagW'(~level_db + 1'b1);
    end
    if (s2_ready && s1_valid) begin
      s2_neg <= s1_neg;
      s2_pos <= prod[dbcm_pkg::RecipShift +: dbcm_pkg::PosW];
    end
  end

  assign out_valid = s2_valid;
  assign out_neg   = s2_neg;
  assign out_pos   = s2_pos;

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    s2_valid && s2_neg |-> s2_pos <= 13'd6553)
    else $error("quotient out of range");

  a_rst_clear: assert property (@(posedge clk)
    rst |=> !s1_valid && !s2_valid)
    else $error("stage valid after reset");

endmodule

// ===== hw/rtl/dbcm_lookup.sv =====
// dbcm_lookup: one stage, selects bounding rows and blend fraction, or white/black.
// Depends on dbcm_pkg.
module dbcm_lookup (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_neg,
  input  logic [dbcm_pkg::PosW-1:0]      in_pos,
  output logic                           out_valid,
  input  logic                           out_ready,
  output dbcm_pkg::rgb_t                 out_lo,
  output dbcm_pkg::rgb_t                 out_hi,
  output logic [dbcm_pkg::FracW-1:0]     out_f
);

  logic [dbcm_pkg::IdxW-1:0]  idx;
  logic [dbcm_pkg::FracW-1:0] frac;
  dbcm_pkg::rgb_t             lo;
  dbcm_pkg::rgb_t             hi;
  logic [dbcm_pkg::FracW-1:0] f_sel;
  logic                       valid;
  dbcm_pkg::rgb_t             lo_q;
  dbcm_pkg::rgb_t             hi_q;
  logic [dbcm_pkg::FracW-1:0] f_q;

  assign idx  = in_pos[dbcm_pkg::PosW-1 -: dbcm_pkg::IdxW];
  assign frac = in_pos[dbcm_pkg::FracW-1:0];

  always_comb begin
    if (!in_neg) begin
      lo    = dbcm_pkg::White;
      hi    = dbcm_pkg::White;
      f_sel = '0;
    end else if (idx >= dbcm_pkg::BlackIdx) begin
      lo    = dbcm_pkg::Black;
      hi    = dbcm_pkg::Black;
      f_sel = '0;
    end else begin
      lo    = dbcm_pkg::colour_row(idx);
      hi    = dbcm_pkg::colour_row(idx + 1'b1);
      f_sel = frac;
    end
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      lo_q <= lo;
      hi_q <= hi;
      f_q  <= f_sel;
    end
  end

  assign out_valid = valid;
  assign out_lo    = lo_q;
  assign out_hi    = hi_q;
  assign out_f     = f_q;

  a_white: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !in_neg |=> lo_q == dbcm_pkg::White && f_q == '0)
    else $error("non-negative level not mapped to white");

endmodule

// ===== hw/rtl/dbcm_blend.sv =====
// dbcm_blend: one stage, per-channel linear blend with half-up rounding into the output register.
// Depends on dbcm_pkg.
module dbcm_blend (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  dbcm_pkg::rgb_t                 in_lo,
  input  dbcm_pkg::rgb_t                 in_hi,
  input  logic [dbcm_pkg::FracW-1:0]     in_f,
  output logic                           out_valid,
  input  logic                           out_ready,
  output dbcm_pkg::rgb_t                 out_rgb
);

  localparam int SumW = dbcm_pkg::ChanW + dbcm_pkg::FracW;
  localparam logic [SumW-1:0] Half = SumW'(1 << (dbcm_pkg::FracW-1));

  logic [dbcm_pkg::FracW:0] w_lo;
  logic [SumW-1:0]          sum_r;
  logic [SumW-1:0]          sum_g;
  logic [SumW-1:0]          sum_b;
  logic                     valid;
  dbcm_pkg::rgb_t           rgb_q;

  assign w_lo = (dbcm_pkg::FracW+1)'(1 << dbcm_pkg::FracW) - {1'b0, in_f};

  // sum never exceeds 255*256+128, so it fits SumW bits
  assign sum_r = SumW'(in_lo.r) * SumW'(w_lo) + SumW'(in_hi.r) * SumW'(in_f) + Half;
  assign sum_g = SumW'(in_lo.g) * SumW'(w_lo) + SumW'(in_hi.g) * SumW'(in_f) + Half;
  assign sum_b = SumW'(in_lo.b) * SumW'(w_lo) + SumW'(in_hi.b) * SumW'(in_f) + Half;

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      rgb_q.r <= sum_r[SumW-1 -: dbcm_pkg::ChanW];
      rgb_q.g <= sum_g[SumW-1 -: dbcm_pkg::ChanW];
      rgb_q.b <= sum_b[SumW-1 -: dbcm_pkg::ChanW];
    end
  end

  assign out_valid = valid;
  assign out_rgb   = rgb_q;

  a_exact_row: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_f == '0 |=> rgb_q == $past(in_lo))
    else $error("zero fraction does not give the lower row");

endmodule

// ===== hw/rtl/db_level_colour_map_core.sv =====
// db_level_colour_map_core: top level, maps a Q8.8 dB level to an RGB colour.
// Depends on dbcm_pkg, dbcm_front, dbcm_lookup, dbcm_blend.
//
//   channel | beat fields         | handshake
//   --------+---------------------+--------------------
//   in      | level_db            | in_valid / in_stall
//   out     | red, green, blue    | out_valid / out_stall
//
// One beat per cycle sustained while out_stall is low; the stages are magnitude,
// divide-by-10 multiply, table lookup and blend into the output register.
// Each stage holds its own valid bit and fills when empty or moving, so bubbles collapse.
// A stalled output freezes only the unbroken run of full stages directly behind it.
// rst clears all valid bits; the data registers are not reset.
module db_level_colour_map_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [dbcm_pkg::LevelW-1:0]   level_db,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dbcm_pkg::ChanW-1:0]    red,
  output logic [dbcm_pkg::ChanW-1:0]    green,
  output logic [dbcm_pkg::ChanW-1:0]    blue
);

  logic                         fr_in_ready;
  logic                         fr_valid;
  logic                         fr_ready;
  logic                         fr_neg;
  logic [dbcm_pkg::PosW-1:0]    fr_pos;
  logic                         lk_valid;
  logic                         lk_ready;
  dbcm_pkg::rgb_t               lk_lo;
  dbcm_pkg::rgb_t               lk_hi;
  logic [dbcm_pkg::FracW-1:0]   lk_f;
  dbcm_pkg::rgb_t               rgb;

  dbcm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (fr_in_ready),
    .level_db  (level_db),
    .out_valid (fr_valid),
    .out_ready (fr_ready),
    .out_neg   (fr_neg),
    .out_pos   (fr_pos)
  );

  dbcm_lookup u_lookup (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_neg    (fr_neg),
    .in_pos    (fr_pos),
    .out_valid (lk_valid),
    .out_ready (lk_ready),
    .out_lo    (lk_lo),
    .out_hi    (lk_hi),
    .out_f     (lk_f)
  );

  dbcm_blend u_blend (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (lk_valid),
    .in_ready  (lk_ready),
    .in_lo     (lk_lo),
    .in_hi     (lk_hi),
    .in_f      (lk_f),
    .out_valid (out_valid),
    .out_ready (!out_stall),
    .out_rgb   (rgb)
  );

  assign in_stall = !fr_in_ready;
  assign red      = rgb.r;
  assign green    = rgb.g;
  assign blue     = rgb.b;

endmodule
